// ----- sv/ppa_pkg.sv -----
`timescale 1ns / 1ps

package ppa_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 256;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(PIX_COUNT);

  localparam int COORD_W  = 8;
  localparam int SAMPLE_W = 17;
  localparam int BYTE_W   = 8;
  localparam int PASS_W   = 16;
  localparam int PIXEL_W  = 3 * BYTE_W;

  localparam int NUM_W  = BYTE_W + PASS_W;
  localparam int DEN_W  = PASS_W + 1;
  localparam int QSTEPS = BYTE_W;

  localparam int NSTAGE = QSTEPS + 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(65536);

  typedef struct packed {
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic              in_frame;
    logic [ADDR_W-1:0] addr;
  } tag_t;

endpackage

// ----- sv/progressive_pixel_average.sv -----
`timescale 1ns / 1ps
// An accepted request passes through the registered samples and frame read, the blended
// numerator and the divider stages before its result shows on out_data. One request per
// cycle is taken while requests address different pixels and out_stall does not hold
// the pipeline. A request for a pixel that is still in flight waits until that earlier
// write has reached the frame memory. Synchronous active-low reset empties the pipeline
// and clears pass_count; the frame memory is not cleared.

module progressive_pixel_average import ppa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PASS_W-1:0] cfg_data
);

  logic [PASS_W-1:0]   pass_count_r;
  tag_t                tag_r   [NSTAGE];
  tag_t                tag_nxt [NSTAGE];
  logic [SAMPLE_W-1:0] smp_r   [3];
  logic [SAMPLE_W-1:0] smp_nxt [3];
  logic [NUM_W-1:0]    m_r     [3];
  logic [NUM_W-1:0]    m_nxt   [3];
  logic [DEN_W-1:0]    den_r;
  logic [BYTE_W-1:0]   quo     [3];
  logic [PIXEL_W-1:0]  ram_rdata;

  logic              in_inside;
  logic [ADDR_W-1:0] in_addr;
  logic              hazard;
  logic              dup_s0;
  logic              pipe_adv;
  logic              in_accept;

  assign in_inside = (int'(in_data.column) < FRAME_WIDTH) &&
                     (int'(in_data.row) < FRAME_HEIGHT);
  assign in_addr   = ADDR_W'(int'(in_data.row) * FRAME_WIDTH + int'(in_data.column));

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NSTAGE; k++) begin
      if (tag_r[k].valid && tag_r[k].in_frame && in_inside && tag_r[k].addr == in_addr) begin
        hazard = 1'b1;
      end
    end
  end

  always_comb begin
    dup_s0 = 1'b0;
    for (int k = 1; k < NSTAGE; k++) begin
      if (tag_r[0].valid && tag_r[0].in_frame && tag_r[k].valid && tag_r[k].in_frame &&
          tag_r[k].addr == tag_r[0].addr) begin
        dup_s0 = 1'b1;
      end
    end
  end

  assign pipe_adv  = !tag_r[NSTAGE-1].valid || !out_stall;
  assign in_stall  = !pipe_adv || hazard;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  ppa_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(PIX_COUNT)
  ) u_frame (
    .clk  (clk),
    .we   (tag_r[NSTAGE-1].valid && tag_r[NSTAGE-1].in_frame),
    .waddr(tag_r[NSTAGE-1].addr),
    .wdata({quo[0], quo[1], quo[2]}),
    .re   (in_accept),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    tag_nxt = tag_r;
    if (pipe_adv) begin
      tag_nxt[0] = '{valid: in_accept, in_frame: in_inside, addr: in_addr};
      for (int k = 1; k < NSTAGE; k++) begin
        tag_nxt[k] = tag_r[k-1];
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] saturate(input logic [SAMPLE_W-1:0] s);
    return (s > SAMPLE_ONE) ? SAMPLE_ONE : s;
  endfunction

  always_comb begin
    smp_nxt[0] = saturate(in_data.red_in);
    smp_nxt[1] = saturate(in_data.green_in);
    smp_nxt[2] = saturate(in_data.blue_in);
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [BYTE_W-1:0]     old_b;
    logic [SAMPLE_W+7:0]   scaled;
    logic [BYTE_W-1:0]     t_b;

    assign old_b  = (pass_count_r == '0 || !tag_r[0].in_frame) ? '0 :
                    ram_rdata[(2-c)*BYTE_W +: BYTE_W];
    assign scaled = {smp_r[c], 8'b0} - (SAMPLE_W+8)'(smp_r[c]);
    assign t_b    = scaled[23:16];
    assign m_nxt[c] = NUM_W'(old_b * pass_count_r) + NUM_W'(t_b);

    ppa_div u_div (
      .clk  (clk),
      .en   (pipe_adv),
      .num_i(m_r[c]),
      .den_i(den_r),
      .quo_o(quo[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_count_r <= '0;
      for (int k = 0; k < NSTAGE; k++) begin
        tag_r[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        pass_count_r <= cfg_data;
      end
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      smp_r <= smp_nxt;
      m_r   <= m_nxt;
      den_r <= DEN_W'(pass_count_r) + DEN_W'(1);
    end
  end

  assign out_valid = tag_r[NSTAGE-1].valid;
  assign out_data  = '{red_out: quo[0], green_out: quo[1], blue_out: quo[2]};

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> tag_r[0].valid && tag_r[0].addr == $past(in_addr))
    else $error("accepted request did not enter the first stage");

  a_no_dup_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    !dup_s0)
    else $error("two in-flight requests address the same pixel");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");
`endif

endmodule

// ----- sv/ppa_ram.sv -----
`timescale 1ns / 1ps

module ppa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/ppa_div.sv -----
`timescale 1ns / 1ps

module ppa_div import ppa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [BYTE_W-1:0] quo_o
);

  logic [NUM_W-1:0]  rem_r [QSTEPS];
  logic [DEN_W-1:0]  den_r [QSTEPS];
  logic [BYTE_W-1:0] quo_r [QSTEPS];

  for (genvar k = 0; k < QSTEPS; k++) begin : g_stage
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [BYTE_W-1:0] quo_in;
    logic [NUM_W:0]    dsh;
    logic [NUM_W:0]    diff;
    logic [NUM_W-1:0]  rem_nxt;
    logic [BYTE_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign dsh  = (NUM_W+1)'(den_in) << (QSTEPS - 1 - k);
    assign diff = {1'b0, rem_in} - dsh;

    always_comb begin
      if (diff[NUM_W]) begin
        rem_nxt = rem_in;
        quo_nxt = {quo_in[BYTE_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[NUM_W-1:0];
        quo_nxt = {quo_in[BYTE_W-2:0], 1'b1};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[QSTEPS-1];

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ppa_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLDOFF_LEN   = 400;
  localparam int SEG_REQUESTS  = 46;

  typedef enum logic [1:0] {
    MODE_RECV_BUSY,
    MODE_SEND_BUSY,
    MODE_STEADY
  } idle_mode_t;

  typedef struct {
    logic [PASS_W-1:0] passes;
    in_item_t          req;
    bit                typed;
    out_item_t         want;
  } directed_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [PASS_W-1:0] cfg_data;

  idle_mode_t        idle_mode;
  int                holdoff_left = 0;
  bit                held_off = 0;
  int                cycle_count = 0;
  int                errors = 0;

  logic [PASS_W-1:0]  pass_count_now;
  logic [PIXEL_W-1:0] frame_copy [PIX_COUNT];
  bit                 painted [PIX_COUNT];
  logic [ADDR_W-1:0]  painted_list [$];
  logic [ADDR_W-1:0]  recent_addrs [$];
  out_item_t          averaged_q [$];

  directed_row_t directed_rows [0:16] = '{
    '{16'd0, '{8'd0, 8'd0, 17'd0, 17'd65536, 17'h1FFFF}, 1'b1, '{8'd0, 8'd255, 8'd255}},
    '{16'd0, '{8'd255, 8'd255, 17'd65535, 17'd1, 17'd65536}, 1'b1, '{8'd254, 8'd0, 8'd255}},
    '{16'd0, '{8'd255, 8'd0, 17'h10001, 17'h0FFFF, 17'd32768}, 1'b1,
      '{8'd255, 8'd254, 8'd127}},
    '{16'd0, '{8'd0, 8'd255, 17'd258, 17'd257, 17'h1AAAA}, 1'b1, '{8'd1, 8'd0, 8'd255}},
    '{16'd0, '{8'hAA, 8'h55, 17'h15555, 17'h0AAAA, 17'h05555}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd0, '{8'h55, 8'hAA, 17'h0AAAA, 17'h15555, 17'h1FFFE}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd1, '{8'd0, 8'd0, 17'd65536, 17'd0, 17'd32768}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd1, '{8'd0, 8'd0, 17'd0, 17'd65536, 17'h1FFFF}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd1, '{8'd0, 8'd0, 17'd40000, 17'd40000, 17'd40000}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd1, '{8'd255, 8'd255, 17'd0, 17'd0, 17'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd65535, '{8'd255, 8'd255, 17'd65536, 17'd65536, 17'd65536}, 1'b0,
      '{8'd0, 8'd0, 8'd0}},
    '{16'd65535, '{8'd255, 8'd0, 17'd0, 17'd0, 17'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd65535, '{8'd255, 8'd0, 17'd0, 17'd0, 17'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd65535, '{8'hAA, 8'h55, 17'h1FFFF, 17'd0, 17'd65535}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd65535, '{8'd0, 8'd255, 17'd0, 17'd65536, 17'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{16'd0, '{8'd0, 8'd0, 17'd0, 17'd0, 17'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{16'd0, '{8'd0, 8'd0, 17'd65536, 17'd65536, 17'd65536}, 1'b1, '{8'd255, 8'd255, 8'd255}}
  };

  progressive_pixel_average uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] channel_average(logic [BYTE_W-1:0] old_byte,
                                                         logic [SAMPLE_W-1:0] sample,
                                                         logic [PASS_W-1:0] passes);
    longint unsigned s;
    longint unsigned ob;
    longint unsigned p;
    longint unsigned q;
    s  = (sample > SAMPLE_ONE) ? 64'(SAMPLE_ONE) : 64'(sample);
    ob = 64'(old_byte);
    p  = 64'(passes);
    q  = (ob * p * 64'd65536 + 64'd255 * s) / ((p + 64'd1) * 64'd65536);
    return (q > 64'd255) ? 8'd255 : q[BYTE_W-1:0];
  endfunction

  function automatic out_item_t average_pixel(in_item_t req);
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] old_px;
    out_item_t          res;
    addr   = {req.row, req.column};
    old_px = painted[addr] ? frame_copy[addr] : '0;
    res.red_out   = channel_average(old_px[23:16], req.red_in, pass_count_now);
    res.green_out = channel_average(old_px[15:8], req.green_in, pass_count_now);
    res.blue_out  = channel_average(old_px[7:0], req.blue_in, pass_count_now);
    frame_copy[addr] = {res.red_out, res.green_out, res.blue_out};
    if (!painted[addr]) begin
      painted[addr] = 1'b1;
      painted_list.push_back(addr);
    end
    recent_addrs.push_back(addr);
    if (recent_addrs.size() > 4) begin
      void'(recent_addrs.pop_front());
    end
    return res;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_mode)
      MODE_RECV_BUSY: return 19;
      MODE_SEND_BUSY: return 88;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode)
      MODE_RECV_BUSY: return 88;
      MODE_SEND_BUSY: return 19;
      default: return 0;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SAMPLE_ONE;
      2: return SAMPLE_W'($urandom_range(65537, 131071));
      default: return SAMPLE_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t          req;
    logic [ADDR_W-1:0] addr;
    int                pick;
    pick = $urandom_range(0, 9);
    if (pass_count_now == '0 && pick < 4) begin
      addr = ADDR_W'($urandom_range(0, PIX_COUNT - 1));
    end else if (pick < 7 && recent_addrs.size() != 0) begin
      addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    end else begin
      addr = painted_list[$urandom_range(0, painted_list.size() - 1)];
    end
    req.column   = addr[7:0];
    req.row      = addr[15:8];
    req.red_in   = random_sample();
    req.green_in = random_sample();
    req.blue_in  = random_sample();
    return req;
  endfunction

  task automatic send_request(input in_item_t req, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = average_pixel(req);
    averaged_q.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (averaged_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (NSTAGE + 2) @(posedge clk);
  endtask

  task automatic write_pass_count(input logic [PASS_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    pass_count_now = value;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (idle_mode == MODE_STEADY && !held_off) begin
      held_off     <= 1'b1;
      holdoff_left <= HOLDOFF_LEN;
      out_stall    <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (averaged_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel result, expected none, got %0d/%0d/%0d", $time,
                 out_data.red_out, out_data.green_out, out_data.blue_out);
      end else begin
        want = averaged_q.pop_front();
        if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
            out_data.blue_out !== want.blue_out) begin
          errors++;
          $display("%0t: pixel result mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   $time, want.red_out, want.green_out, want.blue_out,
                   out_data.red_out, out_data.green_out, out_data.blue_out);
        end
      end
    end
  end

  initial begin
    logic [PASS_W-1:0] seg_pass;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    idle_mode      = MODE_RECV_BUSY;
    pass_count_now = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].passes != pass_count_now) begin
        write_pass_count(directed_rows[i].passes);
      end
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0: seg_pass = '0;
          1: seg_pass = PASS_W'($urandom_range(1, 8));
          2: seg_pass = PASS_W'($urandom_range(9, 65534));
          default: seg_pass = '1;
        endcase
        write_pass_count(seg_pass);
        if (seg == 0) begin
          idle_mode <= idle_mode_t'(ph);
        end
        for (int n = 0; n < SEG_REQUESTS; n++) begin
          send_request(random_request(), 1'b0, '0);
        end
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
